// ===== rtl/ffc_pkg.sv =====
// ----------------------------------------------------------------------------
// ffc_pkg
// Shared types, codes and helper functions of the float format converter.
// ----------------------------------------------------------------------------
package ffc_pkg;

    localparam int WORD_BITS  = 64;
    localparam int WIDTH_BITS = 6;
    localparam int BIAS_BITS  = 61;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 61;

    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_OVERFLOW    = 2'd1,
        ST_UNDERFLOW   = 2'd2,
        ST_UNSUPPORTED = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        MODE_PASS  = 2'd0,
        MODE_UNSUP = 2'd1,
        MODE_CONV  = 2'd2
    } t_mode;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SRC_EXP_W  = 3'd0,
        CFG_SRC_FRAC_W = 3'd1,
        CFG_SRC_BIAS   = 3'd2,
        CFG_DST_EXP_W  = 3'd3,
        CFG_DST_FRAC_W = 3'd4,
        CFG_DST_BIAS   = 3'd5
    } t_cfg_idx;

    // format constants derived from the configuration registers
    typedef struct packed {
        t_mode                   mode;
        logic [WIDTH_BITS-1:0]   fs;
        logic [WIDTH_BITS-1:0]   fd;
        logic [WIDTH_BITS-1:0]   sgn_pos;
        logic [WORD_BITS-1:0]    src_mask;
        logic [WORD_BITS-1:0]    exp_mask;
        logic [61:0]             frac_mask;
        logic [62:0]             hidden;
        logic [WORD_BITS-1:0]    bias_adj;
        logic [WORD_BITS-1:0]    sgn_mask;
        logic [WORD_BITS-1:0]    inf_pat;
        logic [WORD_BITS-1:0]    emax;
        logic [WORD_BITS-1:0]    emax_m1;
        logic [WORD_BITS-1:0]    fd_mask;
        logic [WORD_BITS-1:0]    quiet;
        logic                    nan_left;
        logic [WIDTH_BITS-1:0]   nan_sh;
    } t_ffc_cfg;

    function automatic logic [WORD_BITS-1:0] low_mask(input logic [6:0] n);
        return ~({WORD_BITS{1'b1}} << n);
    endfunction

    // position of the highest set bit, zero for an empty word
    function automatic logic [5:0] msb_index(input logic [62:0] m);
        logic [5:0] p;
        p = '0;
        for (int i = 0; i < 63; i++) begin
            if (m[i]) begin
                p = 6'(i);
            end
        end
        return p;
    endfunction

endpackage

// ===== rtl/ffc_cfg.sv =====
// ----------------------------------------------------------------------------
// ffc_cfg
// Checks source and destination formats, picks the conversion mode and
// registers the masks and offsets that the datapath needs.
// ----------------------------------------------------------------------------
module ffc_cfg
    import ffc_pkg::*;
#(
    parameter int WORD_WIDTH = 64
) (
    input  logic                  i_clk,
    input  logic [WIDTH_BITS-1:0] i_src_exp_width,
    input  logic [WIDTH_BITS-1:0] i_src_frac_width,
    input  logic [BIAS_BITS-1:0]  i_src_bias,
    input  logic [WIDTH_BITS-1:0] i_dst_exp_width,
    input  logic [WIDTH_BITS-1:0] i_dst_frac_width,
    input  logic [BIAS_BITS-1:0]  i_dst_bias,
    output t_ffc_cfg              o_cfg
);

    localparam logic [6:0] WordW = 7'(WORD_WIDTH);

    t_ffc_cfg             r_cfg;
    t_ffc_cfg             n_cfg;
    logic [6:0]           sum_s;
    logic [6:0]           sum_d;
    logic                 ok_s;
    logic                 ok_d;
    logic [WORD_BITS-1:0] emax_d;

    always_comb begin
        sum_s  = 7'd1 + {1'b0, i_src_exp_width} + {1'b0, i_src_frac_width};
        sum_d  = 7'd1 + {1'b0, i_dst_exp_width} + {1'b0, i_dst_frac_width};
        ok_s   = (i_src_exp_width != '0) && (i_src_frac_width >= 6'd2) &&
                 (sum_s <= WordW) && (i_src_bias != '0) &&
                 ({3'b000, i_src_bias} < low_mask({1'b0, i_src_exp_width}));
        ok_d   = (i_dst_exp_width != '0) && (i_dst_frac_width >= 6'd2) &&
                 (sum_d <= WordW) && (i_dst_bias != '0) &&
                 ({3'b000, i_dst_bias} < low_mask({1'b0, i_dst_exp_width}));
        emax_d = low_mask({1'b0, i_dst_exp_width});

        n_cfg.mode = MODE_UNSUP;
        if (ok_s && ok_d) begin
            if (i_src_exp_width == i_dst_exp_width &&
                i_src_frac_width == i_dst_frac_width) begin
                n_cfg.mode = (i_src_bias == i_dst_bias) ? MODE_PASS : MODE_UNSUP;
            end else if ((i_src_exp_width <= i_dst_exp_width &&
                          i_src_frac_width <= i_dst_frac_width) ||
                         (i_src_exp_width >= i_dst_exp_width &&
                          i_src_frac_width >= i_dst_frac_width)) begin
                n_cfg.mode = MODE_CONV;
            end
        end

        n_cfg.fs        = i_src_frac_width;
        n_cfg.fd        = i_dst_frac_width;
        n_cfg.sgn_pos   = i_src_exp_width + i_src_frac_width;
        n_cfg.src_mask  = (sum_s <= WordW) ? low_mask(sum_s) : low_mask(WordW);
        n_cfg.exp_mask  = low_mask({1'b0, i_src_exp_width});
        n_cfg.frac_mask = low_mask({1'b0, i_src_frac_width})[61:0];
        n_cfg.hidden    = 63'd1 << i_src_frac_width;
        n_cfg.bias_adj  = {3'b000, i_dst_bias} - {3'b000, i_src_bias} -
                          {58'd0, i_src_frac_width};
        n_cfg.sgn_mask  = 64'd1 << ({1'b0, i_dst_exp_width} + {1'b0, i_dst_frac_width});
        n_cfg.inf_pat   = emax_d << i_dst_frac_width;
        n_cfg.emax      = emax_d;
        n_cfg.emax_m1   = emax_d - 64'd1;
        n_cfg.fd_mask   = low_mask({1'b0, i_dst_frac_width});
        n_cfg.quiet     = 64'd1 << (i_dst_frac_width - 6'd1);
        n_cfg.nan_left  = (i_dst_frac_width >= i_src_frac_width);
        n_cfg.nan_sh    = n_cfg.nan_left ? (i_dst_frac_width - i_src_frac_width)
                                         : (i_src_frac_width - i_dst_frac_width);
    end

    always_ff @(posedge i_clk) begin
        r_cfg <= n_cfg;
    end

    assign o_cfg = r_cfg;

endmodule

// ===== rtl/ffc_pipe.sv =====
// ----------------------------------------------------------------------------
// ffc_pipe
// Conversion datapath: field decode, leading-one search, exponent math,
// alignment shift, rounding and packing, each stage with its own valid bit.
// ----------------------------------------------------------------------------
module ffc_pipe
    import ffc_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_ffc_cfg             i_cfg,
    input  logic                 i_src_valid,
    output logic                 o_src_ready,
    input  logic [WORD_BITS-1:0] i_source_word,
    output logic                 o_res_valid,
    input  logic                 i_res_ready,
    output logic [WORD_BITS-1:0] o_result_word,
    output logic [1:0]           o_status_code
);

    localparam int NSTG = 7;

    logic [NSTG-1:0] r_vld;
    logic [NSTG-1:0] n_vld;
    logic [NSTG-1:0] en;

    // stage registers
    logic [63:0] r_s1_word;

    logic [63:0] r_s2_w;
    logic        r_s2_s;
    logic        r_s2_nan;
    logic        r_s2_inf;
    logic        r_s2_zero;
    logic [61:0] r_s2_f;
    logic [62:0] r_s2_m;
    logic [60:0] r_s2_eeff;

    logic [63:0] r_s3_w;
    logic        r_s3_special;
    logic [63:0] r_s3_spec;
    logic [63:0] r_s3_sgn;
    logic [62:0] r_s3_m;
    logic [5:0]  r_s3_p;
    logic [63:0] r_s3_qk;

    logic [63:0] r_s4_w;
    logic        r_s4_special;
    logic [63:0] r_s4_spec;
    logic [63:0] r_s4_sgn;
    logic [62:0] r_s4_m;
    logic [5:0]  r_s4_p;
    logic [63:0] r_s4_t;

    logic [63:0]       r_s5_w;
    logic              r_s5_special;
    logic [63:0]       r_s5_spec;
    logic [63:0]       r_s5_sgn;
    logic [62:0]       r_s5_m;
    logic              r_s5_under;
    logic              r_s5_big;
    logic signed [8:0] r_s5_sh;
    logic [60:0]       r_s5_texp0;
    logic [60:0]       r_s5_texp1;
    logic              r_s5_ovf0;
    logic              r_s5_ovf1;

    logic [63:0] r_s6_w;
    logic        r_s6_special;
    logic [63:0] r_s6_spec;
    logic [63:0] r_s6_sgn;
    logic [63:0] r_s6_val;
    logic        r_s6_inc;
    logic        r_s6_inx;
    logic        r_s6_under;
    logic [60:0] r_s6_texp0;
    logic [60:0] r_s6_texp1;
    logic        r_s6_ovf0;
    logic        r_s6_ovf1;

    logic [63:0] r_out_word;
    t_status     r_out_status;

    // decode
    logic [63:0] a_w;
    logic [63:0] a_e_full;
    logic [61:0] a_f;
    logic        a_e_zero;
    logic        a_e_ones;

    // leading one and special encodings
    logic [5:0]  b_p;
    logic [63:0] b_qk;
    logic [63:0] b_sgn;
    logic [63:0] b_payload;
    logic [63:0] b_spec;

    // exponent
    logic [63:0] c_t;

    // shift amount and range
    logic              d_under;
    logic [63:0]       d_d;
    logic              d_big;
    logic signed [8:0] d_base;
    logic signed [8:0] d_sh;
    logic [63:0]       d_t1;
    logic              d_ovf0;
    logic              d_ovf1;

    // alignment
    logic [8:0]  e_neg;
    logic [5:0]  e_amt;
    logic [5:0]  e_gidx;
    logic [63:0] e_val;
    logic [63:0] e_lowm;
    logic        e_guard;
    logic        e_sticky;
    logic        e_inc;
    logic        e_inx;

    // round and pack
    logic [63:0] f_r;
    logic [5:0]  f_cidx;
    logic        f_carry;
    logic        f_ovf;
    logic [60:0] f_texp;
    logic [63:0] f_conv;
    t_status     f_conv_st;
    logic [63:0] n_out_word;
    t_status     n_out_status;

    // handshake: a stage loads when empty or when its content moves on
    always_comb begin
        en[NSTG-1] = !r_vld[NSTG-1] || i_res_ready;
        for (int k = NSTG - 2; k >= 0; k--) begin
            en[k] = !r_vld[k] || en[k+1];
        end
        n_vld = {r_vld[NSTG-2:0], i_src_valid};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int k = 0; k < NSTG; k++) begin
                if (en[k]) begin
                    r_vld[k] <= n_vld[k];
                end
            end
        end
    end

    assign o_src_ready   = en[0];
    assign o_res_valid   = r_vld[NSTG-1];
    assign o_result_word = r_out_word;
    assign o_status_code = r_out_status;

    always_comb begin
        a_w      = r_s1_word & i_cfg.src_mask;
        a_e_full = (a_w >> i_cfg.fs) & i_cfg.exp_mask;
        a_f      = a_w[61:0] & i_cfg.frac_mask;
        a_e_zero = (a_e_full == 64'd0);
        a_e_ones = (a_e_full == i_cfg.exp_mask);
    end

    always_comb begin
        b_p       = msb_index(r_s2_m);
        b_qk      = {3'b000, r_s2_eeff} + i_cfg.bias_adj;
        b_sgn     = r_s2_s ? i_cfg.sgn_mask : 64'd0;
        b_payload = i_cfg.nan_left ? {2'b00, r_s2_f << i_cfg.nan_sh}
                                   : {2'b00, r_s2_f >> i_cfg.nan_sh};
        if (r_s2_zero) begin
            b_spec = b_sgn;
        end else if (r_s2_inf) begin
            b_spec = b_sgn | i_cfg.inf_pat;
        end else begin
            b_spec = b_sgn | i_cfg.inf_pat | b_payload | i_cfg.quiet;
        end
    end

    assign c_t = r_s3_qk + {58'd0, r_s3_p};

    always_comb begin
        d_under = ($signed(r_s4_t) < 64'sd1);
        d_d     = 64'd1 - r_s4_t;
        d_big   = d_under && (d_d > 64'd127);
        d_base  = $signed({3'b000, r_s4_p}) - $signed({3'b000, i_cfg.fd});
        d_sh    = d_base + (d_under ? $signed({2'b00, d_d[6:0]}) : 9'sd0);
        d_t1    = r_s4_t + 64'd1;
        d_ovf0  = ($signed(r_s4_t) >= $signed(i_cfg.emax));
        d_ovf1  = ($signed(r_s4_t) >= $signed(i_cfg.emax_m1));
    end

    always_comb begin
        e_neg    = '0;
        e_amt    = '0;
        e_gidx   = '0;
        e_lowm   = '0;
        e_guard  = 1'b0;
        e_sticky = 1'b0;
        e_val    = '0;
        e_inc    = 1'b0;
        e_inx    = 1'b0;
        if (r_s5_big || r_s5_sh >= 9'sd64) begin
            e_inx = (r_s5_m != '0);
        end else if (r_s5_sh <= 9'sd0) begin
            e_neg = 9'(-r_s5_sh);
            e_val = {1'b0, r_s5_m} << e_neg[5:0];
        end else begin
            e_amt    = r_s5_sh[5:0];
            e_gidx   = e_amt - 6'd1;
            e_val    = {1'b0, r_s5_m} >> e_amt;
            e_guard  = r_s5_m[e_gidx];
            e_lowm   = low_mask({1'b0, e_gidx});
            e_sticky = |({1'b0, r_s5_m} & e_lowm);
            e_inc    = e_guard && (e_sticky || e_val[0]);
            e_inx    = e_guard || e_sticky;
        end
    end

    always_comb begin
        f_r     = r_s6_val + {63'd0, r_s6_inc};
        f_cidx  = i_cfg.fd + 6'd1;
        f_carry = f_r[f_cidx];
        f_ovf   = f_carry ? r_s6_ovf1 : r_s6_ovf0;
        f_texp  = f_carry ? r_s6_texp1 : r_s6_texp0;
        if (r_s6_under) begin
            f_conv    = r_s6_sgn | f_r;
            f_conv_st = r_s6_inx ? ST_UNDERFLOW : ST_OK;
        end else if (f_ovf) begin
            f_conv    = r_s6_sgn | i_cfg.inf_pat;
            f_conv_st = ST_OVERFLOW;
        end else begin
            f_conv    = r_s6_sgn | ({3'b000, f_texp} << i_cfg.fd) |
                        (f_carry ? 64'd0 : (f_r & i_cfg.fd_mask));
            f_conv_st = ST_OK;
        end
        if (r_s6_special) begin
            f_conv    = r_s6_spec;
            f_conv_st = ST_OK;
        end

        unique case (i_cfg.mode)
            MODE_PASS: begin
                n_out_word   = r_s6_w;
                n_out_status = ST_OK;
            end
            MODE_CONV: begin
                n_out_word   = f_conv;
                n_out_status = f_conv_st;
            end
            default: begin
                n_out_word   = r_s6_w;
                n_out_status = ST_UNSUPPORTED;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_s1_word <= i_source_word;
        end
        if (en[1]) begin
            r_s2_w    <= a_w;
            r_s2_s    <= a_w[i_cfg.sgn_pos];
            r_s2_nan  <= a_e_ones && (a_f != '0);
            r_s2_inf  <= a_e_ones && (a_f == '0);
            r_s2_zero <= a_e_zero && (a_f == '0);
            r_s2_f    <= a_f;
            r_s2_m    <= a_e_zero ? {1'b0, a_f} : (i_cfg.hidden | {1'b0, a_f});
            r_s2_eeff <= a_e_zero ? 61'd1 : a_e_full[60:0];
        end
        if (en[2]) begin
            r_s3_w       <= r_s2_w;
            r_s3_special <= r_s2_nan || r_s2_inf || r_s2_zero;
            r_s3_spec    <= b_spec;
            r_s3_sgn     <= b_sgn;
            r_s3_m       <= r_s2_m;
            r_s3_p       <= b_p;
            r_s3_qk      <= b_qk;
        end
        if (en[3]) begin
            r_s4_w       <= r_s3_w;
            r_s4_special <= r_s3_special;
            r_s4_spec    <= r_s3_spec;
            r_s4_sgn     <= r_s3_sgn;
            r_s4_m       <= r_s3_m;
            r_s4_p       <= r_s3_p;
            r_s4_t       <= c_t;
        end
        if (en[4]) begin
            r_s5_w       <= r_s4_w;
            r_s5_special <= r_s4_special;
            r_s5_spec    <= r_s4_spec;
            r_s5_sgn     <= r_s4_sgn;
            r_s5_m       <= r_s4_m;
            r_s5_under   <= d_under;
            r_s5_big     <= d_big;
            r_s5_sh      <= d_sh;
            r_s5_texp0   <= r_s4_t[60:0];
            r_s5_texp1   <= d_t1[60:0];
            r_s5_ovf0    <= d_ovf0;
            r_s5_ovf1    <= d_ovf1;
        end
        if (en[5]) begin
            r_s6_w       <= r_s5_w;
            r_s6_special <= r_s5_special;
            r_s6_spec    <= r_s5_spec;
            r_s6_sgn     <= r_s5_sgn;
            r_s6_val     <= e_val;
            r_s6_inc     <= e_inc;
            r_s6_inx     <= e_inx;
            r_s6_under   <= r_s5_under;
            r_s6_texp0   <= r_s5_texp0;
            r_s6_texp1   <= r_s5_texp1;
            r_s6_ovf0    <= r_s5_ovf0;
            r_s6_ovf1    <= r_s5_ovf1;
        end
        if (en[6]) begin
            r_out_word   <= n_out_word;
            r_out_status <= n_out_status;
        end
    end

    // an overflow result is a signed infinity
    a_ovf_is_inf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && o_status_code == ST_OVERFLOW
        |-> (o_result_word & ~i_cfg.sgn_mask) == i_cfg.inf_pat)
        else $error("overflow result is not infinity");

    // rounding status only comes out of a real conversion
    a_round_status_conv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && (o_status_code == ST_OVERFLOW || o_status_code == ST_UNDERFLOW)
        |-> i_cfg.mode == MODE_CONV)
        else $error("rounding status outside conversion mode");

    // converted words never set bits above the sign
    a_upper_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && i_cfg.mode == MODE_CONV
        |-> (o_result_word & ~((i_cfg.sgn_mask << 1) - 64'd1)) == 64'd0)
        else $error("converted word has bits above the sign");

    // status unsupported only where the formats are rejected
    a_unsup_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && o_status_code == ST_UNSUPPORTED |-> i_cfg.mode == MODE_UNSUP)
        else $error("unsupported status in a supported mode");

    // an empty output stage lets the whole pipe advance
    a_drain_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_vld[NSTG-1] |-> o_src_ready)
        else $error("pipe stalls with an empty output stage");

endmodule

// ===== rtl/float_format_converter.sv =====
// ----------------------------------------------------------------------------
// float_format_converter
// Converts one binary floating-point word between two configurable formats
// with round to nearest, ties to even, and reports a status code.
//
//   channel   direction  handshake                   payload
//   source    in         i_src_valid / o_src_ready   i_source_word
//   result    out        o_res_valid / i_res_ready   o_result_word, o_status_code
//   config    in         i_cfg_we                    i_cfg_index, i_cfg_data
//
// One word per cycle unless a stalled result has filled the pipe; each word
// passes the register stages of the datapath in order (input, decode, leading
// one, exponent add, range and shift amount, alignment, round and pack).
// Format constants are re-registered every cycle from the config registers.
// Reset clears all stage valid bits and loads binary64 to binary16.
// A stalled result holds in the output stage; earlier stages keep filling
// until they are full, without losing or repeating a word.
// ----------------------------------------------------------------------------
module float_format_converter
    import ffc_pkg::*;
#(
    parameter int WORD_WIDTH = 64
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_src_valid,
    output logic                  o_src_ready,
    input  logic [WORD_BITS-1:0]  i_source_word,
    output logic                  o_res_valid,
    input  logic                  i_res_ready,
    output logic [WORD_BITS-1:0]  o_result_word,
    output logic [1:0]            o_status_code
);

    logic [WIDTH_BITS-1:0] r_src_exp_width;
    logic [WIDTH_BITS-1:0] r_src_frac_width;
    logic [BIAS_BITS-1:0]  r_src_bias;
    logic [WIDTH_BITS-1:0] r_dst_exp_width;
    logic [WIDTH_BITS-1:0] r_dst_frac_width;
    logic [BIAS_BITS-1:0]  r_dst_bias;
    t_ffc_cfg              cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_exp_width  <= 6'd11;
            r_src_frac_width <= 6'd52;
            r_src_bias       <= 61'd1023;
            r_dst_exp_width  <= 6'd5;
            r_dst_frac_width <= 6'd10;
            r_dst_bias       <= 61'd15;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_SRC_EXP_W:  r_src_exp_width  <= i_cfg_data[WIDTH_BITS-1:0];
                CFG_SRC_FRAC_W: r_src_frac_width <= i_cfg_data[WIDTH_BITS-1:0];
                CFG_SRC_BIAS:   r_src_bias       <= i_cfg_data[BIAS_BITS-1:0];
                CFG_DST_EXP_W:  r_dst_exp_width  <= i_cfg_data[WIDTH_BITS-1:0];
                CFG_DST_FRAC_W: r_dst_frac_width <= i_cfg_data[WIDTH_BITS-1:0];
                CFG_DST_BIAS:   r_dst_bias       <= i_cfg_data[BIAS_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    ffc_cfg #(
        .WORD_WIDTH (WORD_WIDTH)
    ) u_cfg (
        .i_clk            (i_clk),
        .i_src_exp_width  (r_src_exp_width),
        .i_src_frac_width (r_src_frac_width),
        .i_src_bias       (r_src_bias),
        .i_dst_exp_width  (r_dst_exp_width),
        .i_dst_frac_width (r_dst_frac_width),
        .i_dst_bias       (r_dst_bias),
        .o_cfg            (cfg)
    );

    ffc_pipe u_pipe (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (cfg),
        .i_src_valid   (i_src_valid),
        .o_src_ready   (o_src_ready),
        .i_source_word (i_source_word),
        .o_res_valid   (o_res_valid),
        .i_res_ready   (i_res_ready),
        .o_result_word (o_result_word),
        .o_status_code (o_status_code)
    );

endmodule
